// ===== rtl/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared codes, widths and controller/datapath handshake types for the
// chained hash key-value table.
// ----------------------------------------------------------------------------
package chkv_pkg;

    localparam int FUNC_W = 2;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    // Operation codes; the unused code behaves as a search
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED       = 3'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED       = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED        = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVE_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND          = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND      = 3'd5;
    localparam logic [STAT_W-1:0] ST_BUCKET_FULL    = 3'd6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input item and start the hash
        logic clr;     // clear one bucket's valid row during the reset sweep
        logic rd;      // read the hashed bucket's rows
        logic exec;    // compare and build the updated rows
        logic commit;  // write back, update the count, load the result
    } chkv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mod_done;  // bucket index is ready
        logic clr_last;  // the sweep is at the last bucket
        logic out_busy;  // the result register cannot take a new result
    } chkv_stat_t;

endpackage

// ===== rtl/chkv_ram.sv =====
// ----------------------------------------------------------------------------
// chkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/chkv_mod.sv =====
// ----------------------------------------------------------------------------
// chkv_mod
// Bucket index unit: key modulo BUCKETS. A power-of-two bucket count is a
// registered mask; any other count is reduced two key bits a cycle.
// ----------------------------------------------------------------------------
module chkv_mod #(
    parameter int BUCKETS = 16,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [chkv_pkg::KEY_W-1:0] key,
    output logic [BW-1:0]            bucket,
    output logic                     done
);

    import chkv_pkg::*;

    logic [BW-1:0] rem_reg;
    logic          done_reg;

    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0)
        begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= BW'(key & KEY_W'(BUCKETS - 1));
                end
            end
        end
        else
        begin : g_iter
            localparam int STEPS = KEY_W / 2;
            localparam int SW    = $clog2(STEPS);
            localparam logic [BW+1:0] B1 = (BW + 2)'(BUCKETS);
            localparam logic [BW+1:0] B2 = (BW + 2)'(2 * BUCKETS);
            localparam logic [BW+1:0] B3 = (BW + 2)'(3 * BUCKETS);

            logic [KEY_W-1:0] shift_reg;
            logic [SW-1:0]    step_reg;
            logic             busy_reg;
            logic [BW+1:0]    part;
            logic [BW+1:0]    part_red;

            // Fold in the next two key bits, then reduce below BUCKETS
            always_comb
            begin
                part = {rem_reg, shift_reg[KEY_W-1 -: 2]};
                if (part >= B3)
                begin
                    part_red = part - B3;
                end
                else if (part >= B2)
                begin
                    part_red = part - B2;
                end
                else if (part >= B1)
                begin
                    part_red = part - B1;
                end
                else
                begin
                    part_red = part;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        step_reg <= '0;
                    end
                    else if (busy_reg)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == SW'(STEPS - 1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    shift_reg <= key;
                    rem_reg   <= '0;
                end
                else if (busy_reg)
                begin
                    shift_reg <= {shift_reg[KEY_W-3:0], 2'b00};
                    rem_reg   <= part_red[BW-1:0];
                end
            end
        end
    endgenerate

    assign bucket = rem_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/chkv_dp.sv =====
// ----------------------------------------------------------------------------
// chkv_dp
// Datapath: input capture, bucket index, slot row memories, way compare,
// row update, entry count and the result register.
// ----------------------------------------------------------------------------
module chkv_dp #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  chkv_pkg::chkv_cmd_t           cmd,
    output chkv_pkg::chkv_stat_t          stat,
    input  logic [chkv_pkg::FUNC_W-1:0]   in_func,
    input  logic [chkv_pkg::KEY_W-1:0]    in_key,
    input  logic [chkv_pkg::VAL_W-1:0]    in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [chkv_pkg::STAT_W-1:0]   out_status,
    output logic                          out_empty
);

    import chkv_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(BUCKETS * WAYS + 1);

    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;
    logic [BW-1:0]         bucket;
    logic                  mod_done;
    logic [BW-1:0]         clr_addr_reg;
    logic [CW-1:0]         count_reg;

    logic [WAYS-1:0]       vrow;
    logic [WAYS*KEY_W-1:0] krow;
    logic [WAYS*VAL_W-1:0] drow;

    logic [WAYS-1:0]       vrow_next;
    logic [WAYS*KEY_W-1:0] krow_next;
    logic [WAYS*VAL_W-1:0] drow_next;
    logic [STAT_W-1:0]     status_next;
    logic [CW-1:0]         count_next;
    logic                  wr_next;

    logic [WAYS-1:0]       vrow_new_reg;
    logic [WAYS*KEY_W-1:0] krow_new_reg;
    logic [WAYS*VAL_W-1:0] drow_new_reg;
    logic [STAT_W-1:0]     status_new_reg;
    logic [CW-1:0]         count_new_reg;
    logic                  wr_reg;

    logic                  out_valid_reg;
    logic [STAT_W-1:0]     out_status_reg;
    logic                  out_empty_reg;

    logic [WAYS-1:0]       hit_vec;
    logic                  hit_any;
    logic                  free_any;
    logic [WW-1:0]         hit_idx;
    logic [WW-1:0]         free_idx;

    logic                  v_wr_en;
    logic [BW-1:0]         v_wr_addr;
    logic [WAYS-1:0]       v_wr_data;
    logic                  row_wr_en;

    chkv_mod #(.BUCKETS(BUCKETS)) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.load),
        .key    (in_key),
        .bucket (bucket),
        .done   (mod_done)
    );

    // Capture the item on accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign row_wr_en = cmd.commit & wr_reg;
    assign v_wr_en   = row_wr_en | cmd.clr;
    assign v_wr_addr = cmd.clr ? clr_addr_reg : bucket;
    assign v_wr_data = cmd.clr ? '0 : vrow_new_reg;

    chkv_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
        .clk     (clk),
        .wr_en   (v_wr_en),
        .wr_addr (v_wr_addr),
        .wr_data (v_wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (bucket),
        .rd_data (vrow)
    );

    chkv_ram #(.WIDTH(WAYS * KEY_W), .DEPTH(BUCKETS)) u_key_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (bucket),
        .wr_data (krow_new_reg),
        .rd_en   (cmd.rd),
        .rd_addr (bucket),
        .rd_data (krow)
    );

    chkv_ram #(.WIDTH(WAYS * VAL_W), .DEPTH(BUCKETS)) u_value_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (bucket),
        .wr_data (drow_new_reg),
        .rd_en   (cmd.rd),
        .rd_addr (bucket),
        .rd_data (drow)
    );

    // Way compare and lowest free way
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = vrow[w] && (krow[w*KEY_W +: KEY_W] == key_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WW'(w);
            end
            if (!vrow[w])
            begin
                free_idx = WW'(w);
            end
        end
        hit_any  = |hit_vec;
        free_any = ~&vrow;
    end

    // Build the updated rows and the result
    always_comb
    begin
        vrow_next   = vrow;
        krow_next   = krow;
        drow_next   = drow;
        count_next  = count_reg;
        wr_next     = 1'b0;
        status_next = hit_any ? ST_FOUND : ST_NOT_FOUND;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (hit_any)
                begin
                    drow_next[hit_idx*VAL_W +: VAL_W] = value_reg;
                    wr_next     = 1'b1;
                    status_next = ST_REPLACED;
                end
                else if (free_any)
                begin
                    vrow_next[free_idx] = 1'b1;
                    krow_next[free_idx*KEY_W +: KEY_W] = key_reg;
                    drow_next[free_idx*VAL_W +: VAL_W] = value_reg;
                    count_next  = count_reg + 1'b1;
                    wr_next     = 1'b1;
                    status_next = ST_INSERTED;
                end
                else
                begin
                    status_next = ST_BUCKET_FULL;
                end
            end
            FN_REMOVE:
            begin
                if (hit_any)
                begin
                    vrow_next[hit_idx] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    wr_next     = 1'b1;
                    status_next = ST_REMOVED;
                end
                else
                begin
                    status_next = ST_REMOVE_MISSING;
                end
            end
            default:
            begin
                status_next = hit_any ? ST_FOUND : ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            vrow_new_reg   <= vrow_next;
            krow_new_reg   <= krow_next;
            drow_new_reg   <= drow_next;
            status_new_reg <= status_next;
            count_new_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg        <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                wr_reg <= wr_next;
            end
            if (cmd.commit)
            begin
                count_reg     <= count_new_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= status_new_reg;
            out_empty_reg  <= (count_new_reg == '0);
        end
    end

    assign stat.mod_done = mod_done;
    assign stat.clr_last = (clr_addr_reg == BW'(BUCKETS - 1));
    assign stat.out_busy = out_valid_reg & ~out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_empty  = out_empty_reg;

endmodule

// ===== rtl/chkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// chkv_ctrl
// Controller: clearing sweep after reset, then accept, hash, read, compare
// and write-back for one item at a time.
// ----------------------------------------------------------------------------
module chkv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output chkv_pkg::chkv_cmd_t  cmd,
    input  chkv_pkg::chkv_stat_t stat
);

    import chkv_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.mod_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // hold the write-back until the result register is free
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_value_table
// Key-value store: key modulo BUCKETS picks a bucket of WAYS slots.
// ----------------------------------------------------------------------------
// Input channel s_axis: one operation per item. tuser carries the operation
// (0 insert or update, 1 remove, 2 or 3 search); tdata carries key and value.
// Output channel m_axis: exactly one result per item, in order, with the
// status code and a flag that is set when the table holds no entry.
// Items are processed one at a time: after the accepting edge the controller
// steps through the hash, row read, compare and write-back states, and only
// then accepts the next item; any BUCKETS that is not a power of two makes
// the hash step wait for the two-bits-a-cycle modulo unit. The bucket row read
// and the single write-back port of the slot memories set this sequence.
// Reset clears the control state, then a clearing pass zeroes the valid row
// of each bucket, one per cycle; s_axis_tready stays low during the pass.
// The result sits in an output register, so a new item is accepted while
// it waits; when the receiver stalls, the next write-back waits for that
// register and s_axis_tready stays low.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[2:0], table_empty[3], zero[7:4]
);

    import chkv_pkg::*;

    chkv_cmd_t         cmd;
    chkv_stat_t        stat;
    logic [STAT_W-1:0] status;
    logic              table_empty;

    chkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    chkv_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_axis_tuser),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .in_value   (s_axis_tdata[KEY_W +: VAL_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status),
        .out_empty  (table_empty)
    );

    assign m_axis_tdata = {4'b0000, table_empty, status};

endmodule

// ===== rtl/chkv_checker.sv =====
// ----------------------------------------------------------------------------
// chkv_checker
// Port-level checks for the chained hash key-value table.
// ----------------------------------------------------------------------------
module chkv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    import chkv_pkg::*;

    // One item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted back to back");

    // A fresh insert leaves at least one entry
    a_insert_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] == ST_INSERTED) |-> !m_axis_tdata[3])
        else $error("table reported empty after an insert");

    // Status code is in range and padding stays zero
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7 && m_axis_tdata[7:4] == 4'd0))
        else $error("illegal result encoding");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== test/tb_chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// tb_chained_hash_key_value_table
// Self-checking bench for the chained hash key-value table. A shadow copy of
// the bucket slots predicts the status and empty flag of every accepted
// operation. Results are compared in order against that prediction while
// both stream sides idle and stall at random across four pressure phases.
// ----------------------------------------------------------------------------
module tb_chained_hash_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    import chkv_pkg::*;

    localparam int BUCKETS      = 16;
    localparam int WAYS         = 4;
    localparam int SLOTS        = BUCKETS * WAYS;
    localparam int PHASES       = 4;
    localparam int OPS_PER_PASS = 200;
    localparam int POOL_SIZE    = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 30;

    // The spare operation code answers like a search
    localparam logic [FUNC_W-1:0] FN_SEARCH_ALT = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        int                phase;
    } op_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              empty;
    } reply_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // key[31:0], value[63:32]
    logic [1:0]  s_axis_tuser  = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // status[2:0], table_empty[3], zero[7:4]

    // Shadow of the slot memories
    logic             shadow_valid [SLOTS];
    logic [KEY_W-1:0] shadow_key   [SLOTS];
    logic [VAL_W-1:0] shadow_value [SLOTS];
    int               shadow_count;

    op_item_t     op_queue[$];
    reply_t       predicted_replies[$];
    op_item_t     next_op;
    reply_t       want;
    int           active_phase = 0;
    int           send_idle_pct  [PHASES] = '{0, 66, 0, 35};
    int           recv_stall_pct [PHASES] = '{0, 0, 66, 35};
    int           errors = 0;
    int           ops_accepted = 0;
    int           replies_seen = 0;
    int           status_seen [8] = '{default: 0};
    int           idle_cycles = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    chained_hash_key_value_table #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one operation to the shadow table and return its reply
    function automatic reply_t apply_table_op(input logic [FUNC_W-1:0] fn,
                                              input logic [KEY_W-1:0] k,
                                              input logic [VAL_W-1:0] v);
        int     base;
        int     hit;
        bit     placed;
        reply_t r;
        base   = int'(k % BUCKETS) * WAYS;
        hit    = -1;
        placed = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit < 0 && shadow_valid[base + w] && shadow_key[base + w] == k)
                hit = base + w;
        end
        if (fn == FN_INSERT)
        begin
            if (hit >= 0)
            begin
                shadow_value[hit] = v;
                r.status = ST_REPLACED;
            end
            else
            begin
                r.status = ST_BUCKET_FULL;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!placed && !shadow_valid[base + w])
                    begin
                        shadow_valid[base + w] = 1'b1;
                        shadow_key[base + w]   = k;
                        shadow_value[base + w] = v;
                        shadow_count++;
                        placed   = 1'b1;
                        r.status = ST_INSERTED;
                    end
                end
            end
        end
        else if (fn == FN_REMOVE)
        begin
            if (hit >= 0)
            begin
                shadow_valid[hit] = 1'b0;
                if (shadow_count > 0)
                    shadow_count--;
                r.status = ST_REMOVED;
            end
            else
                r.status = ST_REMOVE_MISSING;
        end
        else
            r.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic add_op(input int ph, input logic [FUNC_W-1:0] fn,
                          input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
        op_item_t it;
        it.func  = fn;
        it.key   = k;
        it.value = v;
        it.phase = ph;
        op_queue.push_back(it);
    endtask

    // Driver: advance to the next queued item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_replies.push_back(apply_table_op(s_axis_tuser,
                                            s_axis_tdata[31:0], s_axis_tdata[63:32]));
                ops_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (op_queue.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct[op_queue[0].phase])
                begin
                    next_op = op_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_op.value, next_op.key};
                    s_axis_tuser  <= next_op.func;
                    active_phase  <= next_op.phase;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                replies_seen++;
                status_seen[m_axis_tdata[2:0]]++;
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t ns: result with none expected: expected none, got tdata %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_axis_tdata[2:0] != want.status)
                    begin
                        $display("%0t ns: status mismatch: expected %0d, got %0d",
                                 $time, want.status, m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (m_axis_tdata[3] != want.empty)
                    begin
                        $display("%0t ns: table_empty mismatch: expected %0b, got %0b",
                                 $time, want.empty, m_axis_tdata[3]);
                        errors++;
                    end
                    if (m_axis_tdata[7:4] != 4'd0)
                    begin
                        $display("%0t ns: pad bits mismatch: expected 0, got %h",
                                 $time, m_axis_tdata[7:4]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct[active_phase]);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int               roll;
        int               ins_w;
        int               rem_w;
        int               total_ops;
        logic [31:0]      tmp;
        logic [FUNC_W-1:0] fn;
        logic [KEY_W-1:0] k;

        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
        end
        shadow_count = 0;

        // Directed: empty table, extremes, replace, full bucket, spare code
        add_op(0, FN_SEARCH, 32'h0000_0000, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0005, 32'hFFFF_FFFF);
        add_op(0, FN_INSERT, 32'h0000_0000, 32'h0000_0000);
        add_op(0, FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(0, FN_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        add_op(0, FN_INSERT, 32'h0000_0010, 32'hA5A5_A5A5);
        add_op(0, FN_INSERT, 32'h0000_0020, 32'h5A5A_5A5A);
        add_op(0, FN_INSERT, 32'hFFFF_FFF0, 32'h0000_0001);
        add_op(0, FN_INSERT, 32'h0000_0030, 32'h8000_0000);
        add_op(0, FN_SEARCH, 32'h0000_0030, 32'h0000_0000);
        add_op(0, FN_SEARCH_ALT, 32'h0000_0010, 32'hFFFF_FFFF);
        add_op(0, FN_SEARCH_ALT, 32'h0000_0030, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0010, 32'h0000_0000);
        add_op(0, FN_INSERT, 32'h0000_0030, 32'h7FFF_FFFF);
        add_op(0, FN_SEARCH, 32'h0000_0030, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0010, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0000, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0020, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'h0000_0030, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'hFFFF_FFF0, 32'h0000_0000);
        add_op(0, FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        add_op(0, FN_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
        add_op(0, FN_REMOVE, 32'h8000_0000, 32'h0000_0000);

        // Crowd most pool keys into a few buckets so they fill up
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tmp = $urandom();
            key_pool[i] = {tmp[31:4], (i < 30) ? 4'(i % 6) : 4'($urandom_range(0, 15))};
        end

        // Even phases grow the table, odd phases drain it
        for (int ph = 0; ph < PHASES; ph++)
        begin
            ins_w = (ph % 2 == 0) ? 55 : 20;
            rem_w = (ph % 2 == 0) ? 25 : 60;
            for (int n = 0; n < OPS_PER_PASS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_w)
                    fn = FN_INSERT;
                else if (roll < ins_w + rem_w)
                    fn = FN_REMOVE;
                else
                    fn = ($urandom_range(0, 3) == 0) ? FN_SEARCH_ALT : FN_SEARCH;
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    k = $urandom();
                add_op(ph, fn, k, $urandom());
            end
        end
        total_ops = op_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for one result per queued item; the watchdog ends a hung run
        while (replies_seen < total_ops)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations (%0d results) over %0d idle/stall phases.",
                 ops_accepted, replies_seen, PHASES);
        $display("Inserted %0d, replaced %0d, removed %0d, missing %0d, found %0d, absent %0d, full %0d.",
                 status_seen[ST_INSERTED], status_seen[ST_REPLACED], status_seen[ST_REMOVED],
                 status_seen[ST_REMOVE_MISSING], status_seen[ST_FOUND],
                 status_seen[ST_NOT_FOUND], status_seen[ST_BUCKET_FULL]);
        if (predicted_replies.size() != 0)
        begin
            $display("%0t ns: %0d results never arrived", $time, predicted_replies.size());
            errors++;
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
